### rtl/core/f32as_pkg.sv
package f32as_pkg;
  localparam int SigW  = 24;
  localparam int ExpW  = 8;
  localparam int MaxShift = 23;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // leading-zero count of a 24-bit significand
  function automatic logic [4:0] lzc24(input logic [SigW-1:0] v);
    logic [4:0] n;
    logic       hit;
    n = 5'd0;
    hit = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!hit && v[i]) begin
        hit = 1'b1;
        n = 5'(SigW - 1 - i);
      end
    end
    return n;
  endfunction
endpackage

### rtl/core/f32as_align.sv
module f32as_align (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        mode,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_vld,
  output logic        far,
  output logic [31:0] far_word,
  output logic        eff_sub,
  output logic        s_big,
  output logic        s_sml,
  output logic [7:0]  e_big,
  output logic [23:0] m_big,
  output logic [23:0] m_sml
);
  import f32as_pkg::*;
  logic       sb, ge;
  logic [7:0] ea, eb, d;
  logic [23:0] ma, mb, msml_raw;

  always_comb begin
    ea = operand_a[30:23];
    eb = operand_b[30:23];
    ma = (ea != 8'd0) ? {1'b1, operand_a[22:0]} : 24'd0;
    mb = (eb != 8'd0) ? {1'b1, operand_b[22:0]} : 24'd0;
    sb = operand_b[31] ^ (mode & (eb != 8'd0));
    ge = ea >= eb;
    d  = ge ? ea - eb : eb - ea;
    msml_raw = ge ? mb : ma;
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= in_vld;
    far      <= d > 8'(MaxShift);
    far_word <= ge ? {operand_a[31], operand_a[30:0]} : {sb, operand_b[30:0]};
    s_big    <= ge ? operand_a[31] : sb;
    s_sml    <= ge ? sb : operand_a[31];
    eff_sub  <= operand_a[31] != sb;
    e_big    <= ge ? ea : eb;
    m_big    <= ge ? ma : mb;
    m_sml    <= msml_raw >> d[4:0];
  end
endmodule

### rtl/core/f32as_addsub.sv
module f32as_addsub (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        far,
  input  logic [31:0] far_word,
  input  logic        eff_sub,
  input  logic        s_big,
  input  logic        s_sml,
  input  logic [7:0]  e_big,
  input  logic [23:0] m_big,
  input  logic [23:0] m_sml,
  output logic        out_vld,
  output logic        far_q,
  output logic [31:0] far_word_q,
  output logic        eff_sub_q,
  output logic        sign,
  output logic [7:0]  e_q,
  output logic [24:0] mag
);
  logic ge;
  assign ge = m_big >= m_sml;
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= in_vld;
    far_q      <= far;
    far_word_q <= far_word;
    eff_sub_q  <= eff_sub;
    e_q        <= e_big;
    if (!eff_sub) begin
      sign <= s_big;
      mag  <= {1'b0, m_big} + {1'b0, m_sml};
    end else begin
      sign <= ge ? s_big : s_sml;
      mag  <= ge ? {1'b0, m_big - m_sml} : {1'b0, m_sml - m_big};
    end
  end
endmodule

### rtl/core/f32as_norm.sv
module f32as_norm (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        far,
  input  logic [31:0] far_word,
  input  logic        eff_sub,
  input  logic        sign,
  input  logic [7:0]  e_in,
  input  logic [24:0] mag,
  output logic        out_vld,
  output logic [31:0] result_bits,
  output logic        overflowed
);
  import f32as_pkg::*;
  logic [4:0]  lz;
  logic [9:0]  e_sub;
  logic [8:0]  e_inc;
  logic [23:0] m_norm;
  logic [31:0] res;
  logic        ovf;

  always_comb begin
    lz     = lzc24(mag[23:0]);
    m_norm = mag[23:0] << lz;
    e_sub  = {2'b00, e_in} - {5'd0, lz};
    e_inc  = {1'b0, e_in} + 9'd1;
    ovf    = 1'b0;
    if (far) begin
      res = far_word;
    end else if (mag == 25'd0) begin
      res = 32'd0;
    end else if (!eff_sub) begin
      if (mag[24]) begin
        if (e_inc >= {1'b0, ExpMax}) begin
          res = {sign, ExpMax, 23'd0};
          ovf = 1'b1;
        end else begin
          res = {sign, e_inc[7:0], mag[23:1]};
        end
      end else begin
        res = {sign, e_in, mag[22:0]};
      end
    end else if (e_sub[9] || e_sub == 10'd0) begin
      res = 32'd0;
    end else begin
      res = {sign, e_sub[7:0], m_norm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= in_vld;
    result_bits <= res;
    overflowed  <= ovf;
  end
endmodule

### rtl/core/float32_add_sub_core.sv
// channel | handshake            | fields
// input   | start (busy always 0)| mode, operand_a, operand_b
// result  | done strobe, 1 cycle | result_bits, overflowed
// Three registered stages: align, add/subtract, normalize; one word per cycle.
// The shift, the 25-bit add and the leading-zero count each fill one stage.
// Reset (rst, synchronous) clears the stage valid bits only.
// The receiver cannot stall, so the pipe never holds and busy stays low.
module float32_add_sub_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        done,
  output logic [31:0] result_bits,
  output logic        overflowed
);
  logic        v1, far1, es1, sb1, ss1;
  logic [31:0] fw1;
  logic [7:0]  eb1;
  logic [23:0] mb1, ms1;
  logic        v2, far2, es2, sg2;
  logic [31:0] fw2;
  logic [7:0]  e2;
  logic [24:0] mag2;

  // never hold off a word: every stage advances each cycle
  assign busy = 1'b0;

  // stage 1: swap by exponent, flip b for subtract, align the smaller one
  f32as_align u_align (
    .clk, .rst, .in_vld(start), .mode, .operand_a, .operand_b,
    .out_vld(v1), .far(far1), .far_word(fw1), .eff_sub(es1),
    .s_big(sb1), .s_sml(ss1), .e_big(eb1), .m_big(mb1), .m_sml(ms1)
  );

  // stage 2: sign-magnitude add or subtract
  f32as_addsub u_addsub (
    .clk, .rst, .in_vld(v1), .far(far1), .far_word(fw1), .eff_sub(es1),
    .s_big(sb1), .s_sml(ss1), .e_big(eb1), .m_big(mb1), .m_sml(ms1),
    .out_vld(v2), .far_q(far2), .far_word_q(fw2), .eff_sub_q(es2),
    .sign(sg2), .e_q(e2), .mag(mag2)
  );

  // stage 3: normalize, pick special cases, register the result word
  f32as_norm u_norm (
    .clk, .rst, .in_vld(v2), .far(far2), .far_word(fw2), .eff_sub(es2),
    .sign(sg2), .e_in(e2), .mag(mag2),
    .out_vld(done), .result_bits, .overflowed
  );
endmodule

### rtl/core/f32as_checker.sv
module f32as_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] result_bits,
  input logic        overflowed
);
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start ##3 1'b1 |-> done || $past(rst, 1) || $past(rst, 2))
    else $error("word lost in pipe");
  a_nospur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("spurious done");
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    done && overflowed |-> result_bits[30:0] == 31'h7F800000)
    else $error("overflow without infinity");
  a_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
endmodule

bind float32_add_sub_core f32as_checker u_chk (
  .clk, .rst, .start, .busy, .done, .result_bits, .overflowed
);

### tb/sv/tb_top.sv
module tb_top;
  import f32as_pkg::*;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0] bits;
    logic        ovf;
  } sum_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        mode;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        done;
  logic [31:0] result_bits;
  logic        overflowed;

  sum_t sums_due[$];
  int   errors;
  bit   burst_idle;

  float32_add_sub_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result_bits(result_bits), .overflowed(overflowed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Truncating sign-magnitude add or subtract of two single-precision words.
  function automatic sum_t fadd_trunc(input op_e op, input logic [31:0] a,
                                      input logic [31:0] b);
    sum_t        r;
    logic        sa, sb, s_hi, s_lo, sgn;
    logic [7:0]  ea, eb, e_hi, e_lo;
    logic [23:0] ma, mb, m_hi, m_lo;
    logic [30:0] w_hi;
    logic [24:0] mag;
    int          e, d;
    sa = a[31];
    ea = a[30:23];
    sb = b[31];
    eb = b[30:23];
    ma = (ea != 0) ? {1'b1, a[22:0]} : 24'd0;
    mb = (eb != 0) ? {1'b1, b[22:0]} : 24'd0;
    // a zero subtrahend keeps its sign
    if (eb != 0 && op == OP_SUB) sb = ~sb;
    if (ea >= eb) begin
      s_hi = sa; e_hi = ea; m_hi = ma; w_hi = a[30:0];
      s_lo = sb; e_lo = eb; m_lo = mb;
    end else begin
      s_hi = sb; e_hi = eb; m_hi = mb; w_hi = b[30:0];
      s_lo = sa; e_lo = ea; m_lo = ma;
    end
    r.ovf = 1'b0;
    d = int'(e_hi) - int'(e_lo);
    // too far apart: the larger word passes unchanged
    if (d > MaxShift) begin
      r.bits = {s_hi, w_hi};
      return r;
    end
    m_lo = m_lo >> d;
    e = int'(e_hi);
    if (s_hi == s_lo) begin
      sgn = s_hi;
      mag = {1'b0, m_hi} + {1'b0, m_lo};
      if (mag[24]) begin
        mag = mag >> 1;
        e++;
        if (e >= 255) begin
          r.bits = {sgn, 8'hFF, 23'd0};
          r.ovf = 1'b1;
          return r;
        end
      end
      if (mag == 0) begin
        r.bits = 32'd0;
        return r;
      end
    end else begin
      if (m_hi >= m_lo) begin
        mag = {1'b0, m_hi - m_lo};
        sgn = s_hi;
      end else begin
        mag = {1'b0, m_lo - m_hi};
        sgn = s_lo;
      end
      if (mag == 0) begin
        r.bits = 32'd0;
        return r;
      end
      while (!mag[23]) begin
        mag = {1'b0, mag[22:0], 1'b0};
        e--;
      end
      // underflow flushes to plus zero
      if (e <= 0) begin
        r.bits = 32'd0;
        return r;
      end
    end
    r.bits = {sgn, e[7:0], mag[22:0]};
    return r;
  endfunction

  // Drive one word; hold start until the block takes it at a rising edge.
  task automatic send_word(input op_e op, input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (burst_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    mode      <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sums_due.push_back(fadd_trunc(op, a, b));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:23] = 8'hFE;
      3: w[30:23] = 8'h01;
      default: ;
    endcase
    return w;
  endfunction

  // Check each strobed result against the oldest pending sum.
  always @(posedge clk) begin
    sum_t want;
    if (!rst && done) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result bits=%h ovf=%b", $time, result_bits, overflowed);
        errors++;
      end else begin
        want = sums_due.pop_front();
        if (result_bits !== want.bits) begin
          $display("%0t: result_bits expected %h actual %h", $time, want.bits, result_bits);
          errors++;
        end
        if (overflowed !== want.ovf) begin
          $display("%0t: overflowed expected %b actual %b", $time, want.ovf, overflowed);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    op_e op;
    for (int i = 0; i < 2; i++) begin
      op = op_e'(i);
      send_word(op, 32'h0000_0000, 32'h0000_0000);
      send_word(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(op, 32'h7FFF_FFFF, 32'h0000_0000);
      send_word(op, 32'h007F_FFFF, 32'h8000_0000);
    end
  endtask

  task automatic test_special_cases();
    // drop zero-fraction bits, exponents at and past the shift limit, cancellation
    send_word(OP_SUB, 32'h3F80_0000, 32'h0012_3456);
    send_word(OP_ADD, 32'h4B00_0000, 32'h3F80_0000);
    send_word(OP_SUB, 32'h3F80_0000, 32'h4C00_0000);
    send_word(OP_SUB, 32'h3FC0_0000, 32'h3FC0_0000);
    send_word(OP_ADD, 32'h3FC0_0000, 32'hBFC0_0000);
    // underflow after normalization
    send_word(OP_SUB, 32'h0080_0001, 32'h0080_0000);
    send_word(OP_SUB, 32'h0100_0000, 32'h00FF_FFFF);
    // carry into exponent 255, and exponent 255 reached without carry
    send_word(OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_word(OP_SUB, 32'hFF00_0000, 32'h7F00_0000);
    send_word(OP_ADD, 32'h7F80_0000, 32'h3F80_0000);
    send_word(OP_ADD, 32'h7F80_0001, 32'h7F00_0000);
    // exponent difference exactly at the shift limit
    send_word(OP_ADD, 32'h4B7F_FFFF, 32'h3F80_0000);
  endtask

  task automatic test_random(input int count);
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_word();
      b = rand_word();
      // favor near exponents so alignment and cancellation get exercised
      if ($urandom_range(0, 2) == 0) b[30:23] = 8'(a[30:23] + $urandom_range(0, 3) - 1);
      send_word(op_e'($urandom_range(0, 1)), a, b);
    end
  endtask

  initial begin
    int waited;
    errors     = 0;
    burst_idle = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    mode       = OP_ADD;
    operand_a  = '0;
    operand_b  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_special_cases();
    burst_idle = 1'b1;
    test_random(1500);
    burst_idle = 1'b0;
    test_random(330);
    start <= 1'b0;
    waited = 0;
    while (sums_due.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
    if (errors == 0 && sums_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
